// ===== rtl/cfar_2d_cell_averaging_unit_defines.svh =====
// ============================================================================
// CFAR 2-D cell-averaging unit assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ============================================================================
`ifndef CFAR_2D_CELL_AVERAGING_UNIT_DEFINES_SVH
`define CFAR_2D_CELL_AVERAGING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define CFAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CFAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CFAR_ASSERT_NOW(lbl, ante, cons, msg)
`define CFAR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/cfar2d_pkg.sv =====
// ============================================================================
// CFAR 2-D package
// Sizes, register indexes, operation codes and sequencer states.
// ============================================================================
package cfar2d_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_COLS    = 256;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_TRAIN   = 8;
    localparam int MAX_GUARD   = 4;

    localparam int ROW_BITS  = $clog2(MAX_ROWS);
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ADDR_BITS = ROW_BITS + COL_BITS;

    localparam int IDX_BITS   = 8;
    localparam int MOD_BITS   = IDX_BITS + 1;
    localparam int SIZE_BITS  = 9;
    localparam int GUARD_BITS = 3;
    localparam int TRAIN_BITS = 4;
    localparam int SCALE_BITS = 16;
    localparam int SUM_BITS   = 26;
    localparam int FRAC_BITS  = 8;

    localparam int HALF_MAX  = MAX_TRAIN + MAX_GUARD;
    localparam int HALF_BITS = $clog2(HALF_MAX + 1);
    localparam int SPAN_BITS = $clog2(2 * HALF_MAX + 1);
    localparam int CNT_BITS  = $clog2((2 * HALF_MAX + 1) * (2 * HALF_MAX + 1));
    localparam int STEP_BITS = ($clog2(IDX_BITS) > HALF_BITS) ? $clog2(IDX_BITS) : HALF_BITS;

    localparam int MUL_A_BITS = (SAMPLE_BITS > SCALE_BITS) ? SAMPLE_BITS : SCALE_BITS;
    localparam int PROD_BITS  = MUL_A_BITS + SUM_BITS;
    localparam int LHS_BITS   = SAMPLE_BITS + CNT_BITS;
    localparam int CMP_BITS   = (LHS_BITS + FRAC_BITS > PROD_BITS) ?
                                LHS_BITS + FRAC_BITS : PROD_BITS;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    localparam logic [REG_IDX_BITS-1:0] REG_GUARD_ROWS  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_GUARD_COLS  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TRAIN_ROWS  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_TRAIN_COLS  = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SCALE       = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_ROWS_IN_USE = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_COLS_IN_USE = 3'd6;

    localparam logic [GUARD_BITS-1:0] GUARD_RESET = 3'd1;
    localparam logic [TRAIN_BITS-1:0] TRAIN_RESET = 4'd2;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 16'd2560;
    localparam logic [SIZE_BITS-1:0]  ROWS_RESET  = SIZE_BITS'(MAX_ROWS);
    localparam logic [SIZE_BITS-1:0]  COLS_RESET  = SIZE_BITS'(MAX_COLS);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_ROW,
        ST_MOD_COL,
        ST_STORE,
        ST_PRE_ROW,
        ST_PRE_COL,
        ST_SCAN,
        ST_CUT_RD,
        ST_MUL_CUT,
        ST_MUL_NOISE,
        ST_COMPARE
    } t_state;

endpackage

// ===== rtl/cfar_2d_cell_averaging_unit.sv =====
// ============================================================================
// CFAR 2-D cell-averaging unit
// Frame store with a sequenced window sum and a shared multiplier for the
// threshold compare.
// ============================================================================
// In a load item, two 8-step remainder passes reduce row and col to the frame
// in use, then one write goes to the frame memory. A test item sums the
// training cells of a (2*hr+1) by (2*hc+1) window, hr = guard_rows +
// train_rows and hc = guard_cols + train_cols after saturation, read from
// the single-port frame memory one window cell per cycle. o_valid is high
// for exactly one cycle, in the cycle in which busy falls, with the result
// on o_detected, o_noise_sum and o_cell_value; the receiver cannot hold
// it off, so sample it on that cycle. Write the registers only
// while busy is low.
`include "cfar_2d_cell_averaging_unit_defines.svh"

module cfar_2d_cell_averaging_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [cfar2d_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [cfar2d_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [cfar2d_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                   pready,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_operation,
    input  logic [cfar2d_pkg::IDX_BITS-1:0]        i_row,
    input  logic [cfar2d_pkg::IDX_BITS-1:0]        i_col,
    input  logic [cfar2d_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                   o_valid,
    output logic                                   o_detected,
    output logic [cfar2d_pkg::SUM_BITS-1:0]        o_noise_sum,
    output logic [cfar2d_pkg::SAMPLE_BITS-1:0]     o_cell_value
);
    import cfar2d_pkg::*;

    logic [GUARD_BITS-1:0] r_guard_rows, r_guard_cols;
    logic [TRAIN_BITS-1:0] r_train_rows, r_train_cols;
    logic [SCALE_BITS-1:0] r_scale;
    logic [SIZE_BITS-1:0]  r_rows_in_use, r_cols_in_use;

    logic                    cfg_wr;
    logic [REG_IDX_BITS-1:0] cfg_idx;

    logic [SIZE_BITS-1:0]  c_nr, c_nc;
    logic [GUARD_BITS-1:0] c_gr, c_gc;
    logic [TRAIN_BITS-1:0] c_tr, c_tc;
    logic [HALF_BITS-1:0]  a_half_r, a_half_c;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   r_acc_en, n_acc_en;

    logic                   r_op, n_op;
    logic [IDX_BITS-1:0]    r_div, n_div;
    logic [IDX_BITS-1:0]    r_col, n_col;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [IDX_BITS-1:0]    r_rem, n_rem;
    logic [STEP_BITS-1:0]   r_cnt, n_cnt;
    logic [SIZE_BITS-1:0]   r_nr, n_nr, r_nc, n_nc;
    logic [HALF_BITS-1:0]   r_half_r, n_half_r, r_half_c, n_half_c;
    logic [SPAN_BITS-1:0]   r_end_r, n_end_r, r_end_c, n_end_c;
    logic [SPAN_BITS-1:0]   r_glo_r, n_glo_r, r_glo_c, n_glo_c;
    logic [SPAN_BITS-1:0]   r_ghi_r, n_ghi_r, r_ghi_c, n_ghi_c;
    logic [ROW_BITS-1:0]    r_r, n_r, r_rr, n_rr;
    logic [COL_BITS-1:0]    r_c, n_c, r_cc, n_cc, r_cs, n_cs;
    logic [SPAN_BITS-1:0]   r_i, n_i, r_j, n_j;
    logic [SUM_BITS-1:0]    r_sum, n_sum;
    logic [CNT_BITS-1:0]    r_n, n_n;
    logic [SAMPLE_BITS-1:0] r_cell, n_cell;
    logic [LHS_BITS-1:0]    r_lhs, n_lhs;
    logic [PROD_BITS-1:0]   r_rhs, n_rhs;
    logic                   r_detected, n_detected;

    logic [SIZE_BITS-1:0] mod_divisor;
    logic [MOD_BITS-1:0]  mod_shift;
    logic [IDX_BITS-1:0]  mod_rem_next;

    logic [ROW_BITS-1:0] dec_row, inc_row;
    logic [COL_BITS-1:0] dec_col, inc_col;
    logic                in_train;

    logic [MUL_A_BITS-1:0] mul_a;
    logic [SUM_BITS-1:0]   mul_b;
    logic [PROD_BITS-1:0]  mul_prod;

    logic [SAMPLE_BITS-1:0] r_frame_mem [0:(2**ADDR_BITS)-1];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [ADDR_BITS-1:0]   mem_addr;
    logic                   mem_we;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_BITS-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_rows  <= GUARD_RESET;
            r_guard_cols  <= GUARD_RESET;
            r_train_rows  <= TRAIN_RESET;
            r_train_cols  <= TRAIN_RESET;
            r_scale       <= SCALE_RESET;
            r_rows_in_use <= ROWS_RESET;
            r_cols_in_use <= COLS_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_GUARD_ROWS:  r_guard_rows  <= pwdata[GUARD_BITS-1:0];
                REG_GUARD_COLS:  r_guard_cols  <= pwdata[GUARD_BITS-1:0];
                REG_TRAIN_ROWS:  r_train_rows  <= pwdata[TRAIN_BITS-1:0];
                REG_TRAIN_COLS:  r_train_cols  <= pwdata[TRAIN_BITS-1:0];
                REG_SCALE:       r_scale       <= pwdata[SCALE_BITS-1:0];
                REG_ROWS_IN_USE: r_rows_in_use <= pwdata[SIZE_BITS-1:0];
                REG_COLS_IN_USE: r_cols_in_use <= pwdata[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_GUARD_ROWS:  prdata = APB_DATA_BITS'(r_guard_rows);
            REG_GUARD_COLS:  prdata = APB_DATA_BITS'(r_guard_cols);
            REG_TRAIN_ROWS:  prdata = APB_DATA_BITS'(r_train_rows);
            REG_TRAIN_COLS:  prdata = APB_DATA_BITS'(r_train_cols);
            REG_SCALE:       prdata = APB_DATA_BITS'(r_scale);
            REG_ROWS_IN_USE: prdata = APB_DATA_BITS'(r_rows_in_use);
            REG_COLS_IN_USE: prdata = APB_DATA_BITS'(r_cols_in_use);
            default:         prdata = '0;
        endcase
    end

    // saturate the window and frame settings
    always_comb begin
        c_nr = (r_rows_in_use == '0) ? SIZE_BITS'(1) :
               (r_rows_in_use > SIZE_BITS'(MAX_ROWS)) ? SIZE_BITS'(MAX_ROWS) : r_rows_in_use;
        c_nc = (r_cols_in_use == '0) ? SIZE_BITS'(1) :
               (r_cols_in_use > SIZE_BITS'(MAX_COLS)) ? SIZE_BITS'(MAX_COLS) : r_cols_in_use;
        c_gr = (r_guard_rows > GUARD_BITS'(MAX_GUARD)) ? GUARD_BITS'(MAX_GUARD) : r_guard_rows;
        c_gc = (r_guard_cols > GUARD_BITS'(MAX_GUARD)) ? GUARD_BITS'(MAX_GUARD) : r_guard_cols;
        c_tr = (r_train_rows == '0) ? TRAIN_BITS'(1) :
               (r_train_rows > TRAIN_BITS'(MAX_TRAIN)) ? TRAIN_BITS'(MAX_TRAIN) : r_train_rows;
        c_tc = (r_train_cols == '0) ? TRAIN_BITS'(1) :
               (r_train_cols > TRAIN_BITS'(MAX_TRAIN)) ? TRAIN_BITS'(MAX_TRAIN) : r_train_cols;
        a_half_r = HALF_BITS'(c_gr) + HALF_BITS'(c_tr);
        a_half_c = HALF_BITS'(c_gc) + HALF_BITS'(c_tc);
    end

    // shared restoring remainder step
    always_comb begin
        mod_divisor  = (r_state == ST_MOD_COL) ? r_nc : r_nr;
        mod_shift    = {r_rem, r_div[IDX_BITS-1]};
        mod_rem_next = (mod_shift >= MOD_BITS'(mod_divisor)) ?
                       IDX_BITS'(mod_shift - MOD_BITS'(mod_divisor)) : IDX_BITS'(mod_shift);
    end

    // circular pointer steps
    always_comb begin
        dec_row = (r_rr == '0) ? ROW_BITS'(r_nr - SIZE_BITS'(1)) : r_rr - ROW_BITS'(1);
        dec_col = (r_cc == '0) ? COL_BITS'(r_nc - SIZE_BITS'(1)) : r_cc - COL_BITS'(1);
        inc_row = ((SIZE_BITS'(r_rr) + SIZE_BITS'(1)) == r_nr) ? '0 : r_rr + ROW_BITS'(1);
        inc_col = ((SIZE_BITS'(r_cc) + SIZE_BITS'(1)) == r_nc) ? '0 : r_cc + COL_BITS'(1);
        in_train = !((r_i >= r_glo_r) && (r_i <= r_ghi_r) &&
                     (r_j >= r_glo_c) && (r_j <= r_ghi_c));
    end

    // shared multiplier
    always_comb begin
        if (r_state == ST_MUL_CUT) begin
            mul_a = MUL_A_BITS'(r_rd_data);
            mul_b = SUM_BITS'(r_n);
        end else begin
            mul_a = MUL_A_BITS'(r_scale);
            mul_b = r_sum;
        end
        mul_prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    end

    assign mem_we   = (r_state == ST_STORE);
    assign mem_addr = (r_state == ST_SCAN) ? {r_rr, r_cc} : {r_r, r_c};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_mem[mem_addr] <= r_sample;
        end
        r_rd_data <= r_frame_mem[mem_addr];
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = 1'b0;
        n_acc_en   = 1'b0;
        n_op       = r_op;
        n_div      = r_div;
        n_col      = r_col;
        n_sample   = r_sample;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_nr       = r_nr;
        n_nc       = r_nc;
        n_half_r   = r_half_r;
        n_half_c   = r_half_c;
        n_end_r    = r_end_r;
        n_end_c    = r_end_c;
        n_glo_r    = r_glo_r;
        n_glo_c    = r_glo_c;
        n_ghi_r    = r_ghi_r;
        n_ghi_c    = r_ghi_c;
        n_r        = r_r;
        n_c        = r_c;
        n_rr       = r_rr;
        n_cc       = r_cc;
        n_cs       = r_cs;
        n_i        = r_i;
        n_j        = r_j;
        n_sum      = r_acc_en ? r_sum + SUM_BITS'(r_rd_data) : r_sum;
        n_n        = r_n;
        n_cell     = r_cell;
        n_lhs      = r_lhs;
        n_rhs      = r_rhs;
        n_detected = r_detected;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op     = i_operation;
                    n_div    = i_row;
                    n_col    = i_col;
                    n_sample = i_sample;
                    n_rem    = '0;
                    n_cnt    = STEP_BITS'(IDX_BITS - 1);
                    n_sum    = '0;
                    n_n      = '0;
                    n_nr     = c_nr;
                    n_nc     = c_nc;
                    n_half_r = a_half_r;
                    n_half_c = a_half_c;
                    n_end_r  = SPAN_BITS'({a_half_r, 1'b0});
                    n_end_c  = SPAN_BITS'({a_half_c, 1'b0});
                    n_glo_r  = SPAN_BITS'(c_tr);
                    n_glo_c  = SPAN_BITS'(c_tc);
                    n_ghi_r  = SPAN_BITS'(c_tr) + SPAN_BITS'({c_gr, 1'b0});
                    n_ghi_c  = SPAN_BITS'(c_tc) + SPAN_BITS'({c_gc, 1'b0});
                    n_state  = ST_MOD_ROW;
                end
            end
            ST_MOD_ROW: begin
                n_div = r_div << 1;
                n_rem = mod_rem_next;
                n_cnt = r_cnt - STEP_BITS'(1);
                if (r_cnt == '0) begin
                    n_r     = ROW_BITS'(mod_rem_next);
                    n_div   = r_col;
                    n_rem   = '0;
                    n_cnt   = STEP_BITS'(IDX_BITS - 1);
                    n_state = ST_MOD_COL;
                end
            end
            ST_MOD_COL: begin
                n_div = r_div << 1;
                n_rem = mod_rem_next;
                n_cnt = r_cnt - STEP_BITS'(1);
                if (r_cnt == '0) begin
                    n_c = COL_BITS'(mod_rem_next);
                    if (r_op == OP_LOAD) begin
                        n_state = ST_STORE;
                    end else begin
                        n_rr    = r_r;
                        n_cc    = COL_BITS'(mod_rem_next);
                        n_cnt   = STEP_BITS'(r_half_r);
                        n_state = ST_PRE_ROW;
                    end
                end
            end
            ST_STORE: begin
                n_state = ST_IDLE;
            end
            ST_PRE_ROW: begin
                n_rr  = dec_row;
                n_cnt = r_cnt - STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(1)) begin
                    n_cnt   = STEP_BITS'(r_half_c);
                    n_state = ST_PRE_COL;
                end
            end
            ST_PRE_COL: begin
                n_cc  = dec_col;
                n_cnt = r_cnt - STEP_BITS'(1);
                if (r_cnt == STEP_BITS'(1)) begin
                    n_cs    = dec_col;
                    n_i     = '0;
                    n_j     = '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_acc_en = in_train;
                n_n      = r_n + CNT_BITS'(in_train);
                if (r_j == r_end_c) begin
                    n_j  = '0;
                    n_cc = r_cs;
                    n_i  = r_i + SPAN_BITS'(1);
                    n_rr = inc_row;
                    if (r_i == r_end_r) begin
                        n_state = ST_CUT_RD;
                    end
                end else begin
                    n_j  = r_j + SPAN_BITS'(1);
                    n_cc = inc_col;
                end
            end
            ST_CUT_RD: begin
                n_state = ST_MUL_CUT;
            end
            ST_MUL_CUT: begin
                n_cell  = r_rd_data;
                n_lhs   = LHS_BITS'(mul_prod);
                n_state = ST_MUL_NOISE;
            end
            ST_MUL_NOISE: begin
                n_rhs   = mul_prod;
                n_state = ST_COMPARE;
            end
            ST_COMPARE: begin
                n_detected = (CMP_BITS'(r_lhs) << FRAC_BITS) > CMP_BITS'(r_rhs);
                n_valid    = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= 1'b0;
            r_acc_en <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_acc_en <= n_acc_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_div      <= n_div;
        r_col      <= n_col;
        r_sample   <= n_sample;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_nr       <= n_nr;
        r_nc       <= n_nc;
        r_half_r   <= n_half_r;
        r_half_c   <= n_half_c;
        r_end_r    <= n_end_r;
        r_end_c    <= n_end_c;
        r_glo_r    <= n_glo_r;
        r_glo_c    <= n_glo_c;
        r_ghi_r    <= n_ghi_r;
        r_ghi_c    <= n_ghi_c;
        r_r        <= n_r;
        r_c        <= n_c;
        r_rr       <= n_rr;
        r_cc       <= n_cc;
        r_cs       <= n_cs;
        r_i        <= n_i;
        r_j        <= n_j;
        r_sum      <= n_sum;
        r_n        <= n_n;
        r_cell     <= n_cell;
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
        r_detected <= n_detected;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_detected   = r_detected;
    assign o_noise_sum  = r_sum;
    assign o_cell_value = r_cell;

    `CFAR_ASSERT_NOW(a_scan_in_frame, r_state == ST_SCAN, (SIZE_BITS'(r_rr) < r_nr) && (SIZE_BITS'(r_cc) < r_nc), "window pointer outside the frame in use")
    `CFAR_ASSERT_NEXT(a_result_after_compare, r_state == ST_COMPARE, o_valid && (r_state == ST_IDLE), "result strobe missing after compare")
    `CFAR_ASSERT_NOW(a_store_on_load_only, mem_we, r_op == OP_LOAD, "frame write outside a load item")

endmodule
